// File: hw/rtl/kgps_pkg.sv
package kgps_pkg;
  localparam int MaxSeq     = 64;
  localparam int TableDepth = 256;
  localparam int MaxK       = 4;

  localparam logic [2:0] NtInvalid = 3'd4;

  typedef enum logic [1:0] {
    KindTable    = 2'd0,
    KindFallback = 2'd1,
    KindFinished = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    RegGuideLength = 2'd0,
    RegMaxLen      = 2'd1,
    RegGuideStep   = 2'd2,
    RegScanLimit   = 2'd3
  } reg_e;

  typedef struct packed {
    logic [2:0] guide_length;
    logic [7:0] max_len;
    logic [7:0] guide_step;
    logic [5:0] scan_limit;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_count;
    logic start_scan;
    logic skip_step;
    logic begin_kmer;
    logic kmer_step;
    logic adv_step;
    logic adv_load;
    logic take_pos;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       skip_done;
    logic       rd_end;
    logic       kmer_done;
    logic       hit_guide;
    logic       run_over;
    logic       adv_left;
    logic       cur_invalid;
    logic [6:0] cand_pos;
    logic       cand_over;
  } sts_t;

  function automatic logic [2:0] nt_code(input logic [7:0] c);
    logic [2:0] r;
    r = NtInvalid;
    unique case (c)
      8'h41, 8'h61: r = 3'd0;
      8'h43, 8'h63: r = 3'd1;
      8'h47, 8'h67: r = 3'd2;
      8'h54, 8'h74, 8'h55, 8'h75: r = 3'd3;
      default: r = NtInvalid;
    endcase
    return r;
  endfunction
endpackage

// File: hw/rtl/kgps_datapath.sv
module kgps_datapath #(
  parameter int MaxSeq     = kgps_pkg::MaxSeq,
  parameter int TableDepth = kgps_pkg::TableDepth,
  parameter int MaxK       = kgps_pkg::MaxK
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kgps_pkg::cfg_t   cfg_i,
  input  kgps_pkg::cmd_t   cmd_i,
  output kgps_pkg::sts_t   sts_o,
  input  logic             ld_tab_i,
  input  logic             ld_seq_i,
  input  logic [7:0]       table_index_i,
  input  logic             table_guide_i,
  input  logic [7:0]       table_advance_i,
  input  logic [7:0]       seq_char_i,
  input  logic             fallback_i
);
  import kgps_pkg::*;
  localparam int TW = $clog2(TableDepth);
  localparam int SW = $clog2(MaxSeq);

  logic [TableDepth-1:0] valid_q;
  logic [TableDepth-1:0] mark_q;
  logic [7:0] adv_mem [TableDepth];
  logic [2:0] seq_mem [MaxSeq];

  logic [6:0] cnt_q, start_q, rp_q;
  logic [7:0] kmer_q, run_q, left_q;
  logic [2:0] ki_q;
  logic [2:0] cur_q;
  logic [7:0] adv_rd_q;
  logic       mark_rd_q;

  logic [2:0] k_eff;
  logic [7:0] mask;
  logic [TW-1:0] idx;
  logic [7:0] kmer_nx;
  logic [8:0] sum;
  logic [8:0] np;

  always_comb begin
    k_eff = cfg_i.guide_length;
    if (k_eff == 3'd0) k_eff = 3'd1;
    if (k_eff > 3'(MaxK)) k_eff = 3'(MaxK);
    mask = 8'((9'd1 << {k_eff, 1'b0}) - 9'd1);
    idx  = TW'(kmer_q);
    kmer_nx = ({kmer_q[5:0], cur_q[1:0]}) & mask;
    sum = 9'(rp_q) + 9'(adv_rd_q);
    np  = (sum > 9'(k_eff)) ? sum - 9'(k_eff) : 9'd0;
    if (fallback_i) np = 9'(start_q) + 9'(cfg_i.guide_step);
  end

  always_ff @(posedge clk_i) begin
    if (ld_tab_i && table_advance_i != 8'd0) adv_mem[TW'(table_index_i)] <= table_advance_i;
    if (ld_seq_i && cnt_q < 7'(MaxSeq)) seq_mem[SW'(cnt_q)] <= nt_code(seq_char_i);
    adv_rd_q  <= valid_q[idx] ? adv_mem[idx] : 8'd1;
    mark_rd_q <= valid_q[idx] & mark_q[idx];
    cur_q     <= (rp_q < cnt_q) ? seq_mem[SW'(rp_q)] : NtInvalid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      mark_q  <= '0;
      cnt_q <= '0; start_q <= '0; rp_q <= '0;
      kmer_q <= '0; run_q <= '0; left_q <= '0; ki_q <= '0;
    end else begin
      if (ld_tab_i && table_advance_i != 8'd0) begin
        valid_q[TW'(table_index_i)] <= 1'b1;
        mark_q[TW'(table_index_i)]  <= table_guide_i;
      end
      if (ld_seq_i && cnt_q < 7'(MaxSeq)) cnt_q <= cnt_q + 7'd1;
      if (cmd_i.clr_count) cnt_q <= '0;
      if (cmd_i.start_scan) begin
        rp_q <= '0;
      end
      if (cmd_i.skip_step) begin
        // cur_q holds seq at rp_q
        if (cur_q == NtInvalid && rp_q < cnt_q && rp_q < 7'(cfg_i.scan_limit))
          rp_q <= rp_q + 7'd1;
        else start_q <= rp_q;
      end
      if (cmd_i.begin_kmer) begin
        kmer_q <= '0; run_q <= '0; ki_q <= '0;
      end
      if (cmd_i.kmer_step) begin
        rp_q <= rp_q + 7'd1;
        if (cur_q == NtInvalid) begin
          kmer_q <= '0; run_q <= '0; ki_q <= '0;
        end else begin
          kmer_q <= kmer_nx; run_q <= run_q + 8'd1; ki_q <= ki_q + 3'd1;
        end
      end
      if (cmd_i.adv_load) left_q <= adv_rd_q;
      if (cmd_i.adv_step) begin
        rp_q <= rp_q + 7'd1;
        run_q <= run_q + 8'd1;
        left_q <= left_q - 8'd1;
        if (cur_q != NtInvalid) kmer_q <= kmer_nx;
      end
      if (cmd_i.take_pos) begin
        rp_q <= np[6:0];
      end
    end
  end

  assign sts_o.skip_done   = !(cur_q == NtInvalid && rp_q < cnt_q &&
                               rp_q < 7'(cfg_i.scan_limit));
  assign sts_o.rd_end      = rp_q >= cnt_q;
  assign sts_o.kmer_done   = ki_q >= k_eff || run_q >= cfg_i.max_len;
  assign sts_o.hit_guide   = mark_rd_q;
  assign sts_o.run_over    = run_q >= cfg_i.max_len;
  assign sts_o.adv_left    = left_q != 8'd0;
  assign sts_o.cur_invalid = cur_q == NtInvalid;
  assign sts_o.cand_pos    = np[6:0];
  assign sts_o.cand_over   = np > 9'(cfg_i.scan_limit);
endmodule

// File: hw/rtl/kgps_ctrl.sv
module kgps_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           cmd_i,
  input  logic           seq_last_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [5:0]     guide_position_o,
  output logic [1:0]     guide_kind_o,
  output logic           last_result_o,
  output kgps_pkg::cmd_t cmd_o,
  input  kgps_pkg::sts_t sts_i,
  output logic           ld_tab_o,
  output logic           ld_seq_o,
  output logic           fallback_o
);
  import kgps_pkg::*;
  typedef enum logic [3:0] {
    SIdle, SSkipRd, SSkip, SBegin, SKRd, SKmer, SLook, SLook2, SAdvRd, SAdv,
    SEmit, SFinish
  } state_e;

  state_e     state_q;
  logic       vld_q;
  logic [5:0] pos_q;
  logic [1:0] kind_q;
  logic       last_q;
  logic [5:0] ncount_q;
  logic       fb_q;

  logic acc;
  assign in_stall_o = state_q != SIdle;
  assign acc = in_valid_i && state_q == SIdle;
  assign ld_tab_o = acc && !cmd_i;
  assign ld_seq_o = acc && cmd_i;
  assign fallback_o = fb_q;
  assign out_valid_o = vld_q;
  assign guide_position_o = pos_q;
  assign guide_kind_o = kind_q;
  assign last_result_o = last_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.start_scan = acc && cmd_i && seq_last_i;
    unique case (state_q)
      SSkip:  cmd_o.skip_step = 1'b1;
      SBegin: cmd_o.begin_kmer = 1'b1;
      SKmer:  cmd_o.kmer_step = !(sts_i.kmer_done || sts_i.rd_end);
      SLook2: cmd_o.adv_load = 1'b1;
      SAdv:   cmd_o.adv_step = sts_i.adv_left && !sts_i.rd_end;
      SEmit:  cmd_o.take_pos = !sts_i.cand_over && (!vld_q || !out_stall_i);
      SFinish: cmd_o.clr_count = !vld_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; vld_q <= 1'b0; pos_q <= '0; kind_q <= KindTable;
      last_q <= 1'b0; ncount_q <= '0; fb_q <= 1'b0;
    end else begin
      if (vld_q && !out_stall_i) vld_q <= 1'b0;
      unique case (state_q)
        SIdle: if (acc && cmd_i && seq_last_i) begin
          ncount_q <= '0; state_q <= SSkipRd;
        end
        SSkipRd: state_q <= SSkip;
        SSkip: state_q <= sts_i.skip_done ? SBegin : SSkipRd;
        SBegin: state_q <= SKRd;
        SKRd: state_q <= SKmer;
        SKmer: state_q <= (sts_i.kmer_done || sts_i.rd_end) ?
                          (sts_i.rd_end ? SFinish : SLook) : SKRd;
        SLook: state_q <= SLook2;
        SLook2: begin
          if (sts_i.hit_guide) begin
            fb_q <= 1'b0; state_q <= SEmit;
          end else if (sts_i.run_over) begin
            fb_q <= 1'b1; state_q <= SEmit;
          end else state_q <= SAdvRd;
        end
        SAdvRd: state_q <= SAdv;
        SAdv: begin
          if (!sts_i.adv_left || sts_i.rd_end)
            state_q <= sts_i.rd_end ? SFinish : SLook;
          else if (sts_i.cur_invalid) state_q <= SBegin;
          else state_q <= SAdvRd;
        end
        SEmit: begin
          if (sts_i.cand_over) state_q <= SFinish;
          else if (!vld_q || !out_stall_i) begin
            vld_q <= 1'b1; pos_q <= sts_i.cand_pos[5:0];
            kind_q <= fb_q ? KindFallback : KindTable; last_q <= 1'b0;
            ncount_q <= ncount_q + 6'd1;
            state_q <= (ncount_q == 6'd62) ? SFinish : SSkipRd;
          end
        end
        SFinish: if (!vld_q || !out_stall_i) begin
          vld_q <= 1'b1; pos_q <= '0; kind_q <= KindFinished; last_q <= 1'b1;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

// File: hw/rtl/kmer_guide_position_scanner_top.sv
// Channel | valid      | stall       | payload
// in      | in_valid_i | in_stall_o  | cmd, table_*, seq_char, seq_last
// out     | out_valid_o| out_stall_i | guide_position, guide_kind, last_result
// cfg     | APB write/read, 4 registers at 4*i
// Table and character beats are accepted while the scanner is idle; in_stall_o is high during a scan.
// After the last character the scan reads characters, builds k-mers, looks each up in
// the table and emits results, then a finish marker; each decision waits on the
// registered table and sequence reads.
// Reset clears table valid bits, counters and the controller.
// A stalled result holds the scan until it is taken.
module kmer_guide_position_scanner_top #(
  parameter int MaxSeq     = kgps_pkg::MaxSeq,
  parameter int TableDepth = kgps_pkg::TableDepth,
  parameter int MaxK       = kgps_pkg::MaxK
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  table_index_i,
  input  logic        table_guide_i,
  input  logic [7:0]  table_advance_i,
  input  logic [7:0]  seq_char_i,
  input  logic        seq_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  guide_position_o,
  output logic [1:0]  guide_kind_o,
  output logic        last_result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kgps_pkg::*;
  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic ld_tab, ld_seq, fb;
  reg_e ra;
  assign ra = reg_e'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{guide_length: 3'd4, max_len: 8'd24, guide_step: 8'd6, scan_limit: 6'd63};
    end else if (psel && penable && pwrite) begin
      unique case (ra)
        RegGuideLength: cfg_q.guide_length <= pwdata[2:0];
        RegMaxLen:      cfg_q.max_len <= pwdata[7:0];
        RegGuideStep:   cfg_q.guide_step <= pwdata[7:0];
        RegScanLimit:   cfg_q.scan_limit <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ra)
      RegGuideLength: prdata = {29'd0, cfg_q.guide_length};
      RegMaxLen:      prdata = {24'd0, cfg_q.max_len};
      RegGuideStep:   prdata = {24'd0, cfg_q.guide_step};
      RegScanLimit:   prdata = {26'd0, cfg_q.scan_limit};
      default:        prdata = '0;
    endcase
  end

  kgps_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .seq_last_i,
    .out_valid_o, .out_stall_i, .guide_position_o, .guide_kind_o, .last_result_o,
    .cmd_o(cmd), .sts_i(sts), .ld_tab_o(ld_tab), .ld_seq_o(ld_seq), .fallback_o(fb)
  );

  kgps_datapath #(.MaxSeq(MaxSeq), .TableDepth(TableDepth), .MaxK(MaxK)) u_dp (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .cmd_i(cmd), .sts_o(sts),
    .ld_tab_i(ld_tab), .ld_seq_i(ld_seq), .table_index_i, .table_guide_i,
    .table_advance_i, .seq_char_i, .fallback_i(fb)
  );
endmodule

// File: hw/rtl/kgps_checker.sv
module kgps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [5:0] guide_position_o,
  input logic [1:0] guide_kind_o,
  input logic       last_result_o
);
  import kgps_pkg::*;
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> guide_kind_o != 2'd3) else $error("bad kind");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_result_o == (guide_kind_o == KindFinished)))
    else $error("last flag");
  a_fin_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_result_o) |-> guide_position_o == 6'd0) else $error("fin pos");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(guide_position_o))
    else $error("hold");
endmodule

bind kmer_guide_position_scanner_top kgps_checker u_chk (.*);
